// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

    localparam logic [7:0]  SPACE_CHAR     = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR   = 8'h0A;
    localparam logic [7:0]  BACKSPACE_CHAR = 8'h0D;

    // space drawn white on black, the screen contents after reset
    localparam logic [15:0] RESET_BLANK    = 16'h0F20;

    localparam logic [3:0]  RESET_TEXT_COLOUR = 4'hF;
    localparam logic [3:0]  RESET_BACK_COLOUR = 4'h0;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // configuration register indexes
    localparam logic [0:0] REG_TEXT_COLOUR = 1'b0;
    localparam logic [0:0] REG_BACK_COLOUR = 1'b1;

    typedef enum logic [0:0] {
        ACT_PUT  = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_PUT,
        KIND_NEWLINE,
        KIND_BACKSPACE,
        KIND_READ
    } item_kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_PUT,
        DP_NEWLINE,
        DP_SC_READ,
        DP_SC_WRITE,
        DP_SC_BLANK,
        DP_BS_BACK,
        DP_BS_READ,
        DP_BS_CHECK,
        DP_BS_BLANK,
        DP_RD_READ,
        DP_RD_CAPT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_NEWLINE,
        ST_SC_READ,
        ST_SC_WRITE,
        ST_SC_BLANK,
        ST_BS_BACK,
        ST_BS_READ,
        ST_BS_CHECK,
        ST_BS_BLANK,
        ST_RD_READ,
        ST_RD_CAPT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   latch;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       at_home;
        logic       col_zero;
        logic       col_last;
        logic       row_last;
        logic       ptr_last;
        logic       is_space;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    state_t dispatch_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // first work state for the beat on the input
    always_comb
    begin
        unique case (status.kind)
            KIND_READ:      dispatch_state = ST_RD_READ;
            KIND_NEWLINE:   dispatch_state = ST_NEWLINE;
            KIND_BACKSPACE: dispatch_state = status.at_home ? ST_FINISH : ST_BS_BACK;
            KIND_PUT:       dispatch_state = ST_PUT;
            default:        dispatch_state = ST_PUT;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dispatch_state;
                end
            end
            ST_PUT:      state_next = status.col_last ? ST_NEWLINE : ST_FINISH;
            ST_NEWLINE:  state_next = status.row_last ? ST_SC_READ : ST_FINISH;
            ST_SC_READ:  state_next = ST_SC_WRITE;
            ST_SC_WRITE: state_next = status.ptr_last ? ST_SC_BLANK : ST_SC_READ;
            ST_SC_BLANK:
            begin
                if (status.ptr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BS_BACK:  state_next = ST_BS_READ;
            ST_BS_READ:  state_next = status.col_zero ? ST_BS_BLANK : ST_BS_CHECK;
            ST_BS_CHECK: state_next = status.is_space ? ST_BS_READ : ST_BS_BLANK;
            ST_BS_BLANK: state_next = ST_FINISH;
            ST_RD_READ:  state_next = ST_RD_CAPT;
            ST_RD_CAPT:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = s_tvalid ? dispatch_state : ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE) ||
                       ((state_reg == ST_FINISH) && status.out_free);
        cmd.latch    = s_tready && s_tvalid;
        cmd.load_out = (state_reg == ST_FINISH) && status.out_free;
        unique case (state_reg)
            ST_CLEAR:    cmd.op = DP_CLEAR;
            ST_PUT:      cmd.op = DP_PUT;
            ST_NEWLINE:  cmd.op = DP_NEWLINE;
            ST_SC_READ:  cmd.op = DP_SC_READ;
            ST_SC_WRITE: cmd.op = DP_SC_WRITE;
            ST_SC_BLANK: cmd.op = DP_SC_BLANK;
            ST_BS_BACK:  cmd.op = DP_BS_BACK;
            ST_BS_READ:  cmd.op = status.col_zero ? DP_NOP : DP_BS_READ;
            ST_BS_CHECK: cmd.op = DP_BS_CHECK;
            ST_BS_BLANK: cmd.op = DP_BS_BLANK;
            ST_RD_READ:  cmd.op = DP_RD_READ;
            ST_RD_CAPT:  cmd.op = DP_RD_CAPT;
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

// ----- rtl/tcw_datapath.sv -----
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [3:0]            cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(COLS);
    localparam logic [AW-1:0] LAST_PTR = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM   = AW'(CELLS - COLS);

    logic [15:0] mem [CELLS];

    logic [3:0]    text_colour_reg, text_colour_next;
    logic [3:0]    back_colour_reg, back_colour_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]    char_reg, char_next;
    logic          eow_reg, eow_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          scroll_reg, scroll_next;
    logic [15:0]   cell_reg, cell_next;
    logic [15:0]   rdata_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    logic [AW-1:0] cur_addr;
    logic [7:0]    in_char;
    logic [4:0]    in_row;
    logic [6:0]    in_col;
    logic [31:0]   rd_lin;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   draw_blank;
    logic [31:0]   row_w, col_w, idx_w;

    assign in_char    = s_tdata[7:0];
    assign in_row     = s_tdata[12:8];
    assign in_col     = s_tdata[19:13];
    assign cur_addr   = base_reg + AW'(col_reg);
    assign rd_lin     = 32'(in_row) * 32'(COLS) + 32'(in_col);
    assign draw_blank = {back_colour_reg, text_colour_reg, SPACE_CHAR};
    assign row_w      = 32'(row_reg);
    assign col_w      = 32'(col_reg);
    assign idx_w      = 32'(cur_addr);

    always_comb
    begin
        if (action_t'(s_tuser) == ACT_READ)
        begin
            status.kind = KIND_READ;
        end
        else if (in_char == NEWLINE_CHAR)
        begin
            status.kind = KIND_NEWLINE;
        end
        else if (in_char == BACKSPACE_CHAR)
        begin
            status.kind = KIND_BACKSPACE;
        end
        else
        begin
            status.kind = KIND_PUT;
        end
        status.at_home  = (row_reg == '0) && (col_reg == '0);
        status.col_zero = (col_reg == '0);
        status.col_last = (col_reg == LAST_COL);
        status.row_last = (row_reg == LAST_ROW);
        status.ptr_last = (ptr_reg == LAST_PTR);
        status.is_space = (rdata_reg[7:0] == SPACE_CHAR);
        status.out_free = !m_tvalid_reg || m_tready;
    end

    // configuration
    always_comb
    begin
        text_colour_next = text_colour_reg;
        back_colour_next = back_colour_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TEXT_COLOUR: text_colour_next = cfg_wdata;
                REG_BACK_COLOUR: back_colour_next = cfg_wdata;
                default:         text_colour_next = text_colour_reg;
            endcase
        end
    end

    // cursor, pointer and item registers
    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        base_next   = base_reg;
        ptr_next    = ptr_reg;
        char_next   = char_reg;
        eow_next    = eow_reg;
        rd_ok_next  = rd_ok_reg;
        scroll_next = scroll_reg;
        cell_next   = cell_reg;
        mem_we      = 1'b0;
        mem_waddr   = cur_addr;
        mem_wdata   = draw_blank;
        mem_re      = 1'b0;
        mem_raddr   = cur_addr;

        if (cmd.latch)
        begin
            char_next   = in_char;
            eow_next    = s_tlast;
            rd_ok_next  = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLS));
            ptr_next    = rd_lin[AW-1:0];
            scroll_next = 1'b0;
            cell_next   = '0;
        end

        unique case (cmd.op)
            DP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = RESET_BLANK;
                ptr_next  = ptr_reg + AW'(1);
            end
            DP_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {back_colour_reg, text_colour_reg, char_reg};
                if (col_reg != LAST_COL)
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            DP_NEWLINE:
            begin
                col_next = '0;
                if (row_reg == LAST_ROW)
                begin
                    scroll_next = 1'b1;
                    ptr_next    = ROW_STEP;
                end
                else
                begin
                    row_next  = row_reg + RW'(1);
                    base_next = base_reg + ROW_STEP;
                end
            end
            DP_SC_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg;
            end
            DP_SC_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - ROW_STEP;
                mem_wdata = rdata_reg;
                ptr_next  = (ptr_reg == LAST_PTR) ? BOTTOM : ptr_reg + AW'(1);
            end
            DP_SC_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg + AW'(1);
            end
            DP_BS_BACK:
            begin
                if (col_reg == '0)
                begin
                    row_next  = row_reg - RW'(1);
                    col_next  = LAST_COL;
                    base_next = base_reg - ROW_STEP;
                end
                else
                begin
                    col_next = col_reg - CW'(1);
                end
            end
            DP_BS_READ:
            begin
                mem_re = 1'b1;
            end
            DP_BS_CHECK:
            begin
                if (rdata_reg[7:0] == SPACE_CHAR)
                begin
                    col_next = col_reg - CW'(1);
                end
            end
            DP_BS_BLANK:
            begin
                mem_we = 1'b1;
            end
            DP_RD_READ:
            begin
                mem_re    = rd_ok_reg;
                mem_raddr = ptr_reg;
            end
            DP_RD_CAPT:
            begin
                cell_next = rd_ok_reg ? rdata_reg : 16'h0000;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // output register; fields from bit 0: row, col, index, scroll, char, fore, back
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
            out_data_next = {cell_reg[15:12], cell_reg[11:8], cell_reg[7:0], scroll_reg,
                             idx_w[10:0], col_w[6:0], row_w[4:0]};
            out_last_next = eow_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_colour_reg <= RESET_TEXT_COLOUR;
            back_colour_reg <= RESET_BACK_COLOUR;
            row_reg         <= '0;
            col_reg         <= '0;
            base_reg        <= '0;
            ptr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            text_colour_reg <= text_colour_next;
            back_colour_reg <= back_colour_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            base_reg        <= base_next;
            ptr_reg         <= ptr_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        eow_reg      <= eow_next;
        rd_ok_reg    <= rd_ok_next;
        scroll_reg   <= scroll_next;
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Text console writer: a ROWS x COLS screen of 16-bit cells (char in bits 7:0,
// foreground in 11:8, background in 15:12) with a cursor.
// Input beat (s_*): tuser selects put (0) or read (1); tdata carries the
// character, read row and read column; tlast marks the end of a write call.
// Output beat (m_*): one per input beat, cursor after the step, scroll flag,
// the read cell (zero on put); tlast echoes the input tlast.
// Config port: cfg_we/cfg_addr/cfg_wdata set text (0) and back (1) colours;
// write only while no beat is in flight.
// Work is sequenced by the controller over the single-port-write screen RAM;
// a new beat is taken only when the last one is finished. A put that wraps
// the line also takes the newline step; backspace skips back over spaces,
// stopping at column 0, and does nothing at home. A scroll does one RAM read
// and one write per moved cell, then one write per bottom-row cell.
// Reset: cursor to home, colours white on black, then a clearing pass of
// ROWS*COLS cells writes blanks; s_tready stays low during it.
// Stall: the result waits in the output register; the next input beat is
// taken and worked on, but its result waits until m_tready frees the slot.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [3:0]            cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // character[7:0], read_row[12:8], read_col[19:13]
    input  logic [0:0]            s_tuser,   // action[0]
    input  logic                  s_tlast,   // end_of_write
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                             // cursor_index[22:12], did_scroll[23],
                                             // cell_char[31:24], cell_fore[35:32],
                                             // cell_back[39:36]
    output logic                  m_tlast    // write_done
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: clear pass, item dispatch, scroll and backspace walks
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // screen RAM, cursor, colours and the output register
    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- rtl/tcw_checker.sv -----
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic [4:0]  o_row;
    logic [6:0]  o_col;
    logic [10:0] o_idx;
    logic        o_scroll;
    logic [15:0] o_cell;
    logic [31:0] lin;

    assign o_row    = m_tdata[4:0];
    assign o_col    = m_tdata[11:5];
    assign o_idx    = m_tdata[22:12];
    assign o_scroll = m_tdata[23];
    assign o_cell   = m_tdata[39:24];
    assign lin      = 32'(o_row) * 32'(COLS) + 32'(o_col);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(o_col) < 32'(COLS)) && (32'(o_row) < 32'(ROWS)))
        else $error("cursor outside the screen");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (ROWS <= 32) |-> o_idx == lin[10:0])
        else $error("cursor index does not match row and column");

    a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_scroll |->
            (o_row == 5'(ROWS - 1)) && (o_col == 7'd0) && (o_cell == 16'h0000))
        else $error("scroll beat with wrong cursor or cell data");

endmodule

bind text_console_writer_core tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- verif/text_console_writer_core_test.sv -----
module text_console_writer_core_test;
    import tcw_pkg::*;

    localparam int NUM_ROWS = 25;
    localparam int NUM_COLS = 80;
    localparam int NUM_CELLS = NUM_ROWS * NUM_COLS;
    localparam int PHASES = 5;
    localparam int BEATS_PER_PHASE = 240;
    localparam int MAX_REPORTS = 40;
    // worst case is every beat scrolling plus both sides stalling, on top of
    // the clearing pass; taken a few times over
    localparam longint RUN_LIMIT = 64'd12 * 64'd20_000_000;

    // one input beat, as the bench sees it
    typedef struct packed {
        action_t    act;
        logic [7:0] ch;
        logic [4:0] rrow;
        logic [6:0] rcol;
        logic       eow;
    } console_item_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]  back;
        logic [3:0]  fore;
        logic [7:0]  chr;
        logic        scroll;
        logic [10:0] pos;
        logic [6:0]  col;
        logic [4:0]  row;
    } cursor_report_t;

    typedef struct packed {
        logic           done;
        cursor_report_t rep;
    } report_entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_addr = REG_TEXT_COLOUR;
    logic [3:0]            cfg_wdata = 4'h0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = ACT_PUT;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    text_console_writer_core #(
        .ROWS(NUM_ROWS),
        .COLS(NUM_COLS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // character[7:0], read_row[12:8], read_col[19:13]
        .s_tuser(s_tuser),      // action[0]
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // cursor_row[4:0], cursor_col[11:5], cursor_index[22:12],
                                // did_scroll[23], cell_char[31:24], cell_fore[35:32],
                                // cell_back[39:36]
        .m_tlast(m_tlast)
    );

    // ---------------------------------------------------------------
    // Screen model: cell store, cursor and the two colour registers
    // ---------------------------------------------------------------
    logic [15:0] screen_model [NUM_CELLS];
    int          cur_r;
    int          cur_c;
    logic [3:0]  fg_reg;
    logic [3:0]  bg_reg;

    console_item_t char_stream [$];       // beats waiting to be driven
    report_entry_t reports_due [$];       // predicted result beats, oldest first

    bit beat_taken = 1'b0;                // set at posedge on s_* handshake
    int send_gap = 0;                     // remaining idle cycles, sender
    int recv_gap = 0;                     // remaining stall cycles, receiver
    int idle_odds = 0;                    // 1-in-N chance of a burst; 0 = none
    bit failed = 1'b0;
    int err_reports = 0;

    function automatic logic [15:0] paint(logic [7:0] c);
        return {bg_reg, fg_reg, c};
    endfunction

    // move to column 0 of the next row; past the bottom, scroll up one row
    function automatic bit advance_line();
        cur_c = 0;
        cur_r++;
        if (cur_r < NUM_ROWS)
            return 1'b0;
        for (int k = 0; k < (NUM_ROWS - 1) * NUM_COLS; k++)
            screen_model[k] = screen_model[k + NUM_COLS];
        for (int k = (NUM_ROWS - 1) * NUM_COLS; k < NUM_CELLS; k++)
            screen_model[k] = paint(SPACE_CHAR);
        cur_r = NUM_ROWS - 1;
        return 1'b1;
    endfunction

    function automatic report_entry_t apply_to_screen(console_item_t it);
        report_entry_t e;
        logic [15:0]   cell_word;
        bit            scrolled;
        cell_word = '0;
        scrolled = 1'b0;
        if (it.act == ACT_READ)
        begin
            // out-of-range reads return an all-zero cell
            if (it.rrow < NUM_ROWS && it.rcol < NUM_COLS)
                cell_word = screen_model[it.rrow * NUM_COLS + it.rcol];
        end
        else if (it.ch == NEWLINE_CHAR)
        begin
            scrolled = advance_line();
        end
        else if (it.ch == BACKSPACE_CHAR)
        begin
            // at home nothing moves; otherwise step back (wrapping up a row),
            // skip spaces down to column 0 and blank the cell landed on
            if (cur_r != 0 || cur_c != 0)
            begin
                if (cur_c == 0)
                begin
                    cur_r--;
                    cur_c = NUM_COLS - 1;
                end
                else
                begin
                    cur_c--;
                end
                while (cur_c > 0 && screen_model[cur_r * NUM_COLS + cur_c][7:0] == SPACE_CHAR)
                    cur_c--;
                screen_model[cur_r * NUM_COLS + cur_c] = paint(SPACE_CHAR);
            end
        end
        else
        begin
            screen_model[cur_r * NUM_COLS + cur_c] = paint(it.ch);
            cur_c++;
            if (cur_c >= NUM_COLS)
                scrolled = advance_line();
        end
        e.done       = it.eow;
        e.rep.row    = 5'(cur_r);
        e.rep.col    = 7'(cur_c);
        e.rep.pos    = 11'(cur_r * NUM_COLS + cur_c);
        e.rep.scroll = scrolled;
        e.rep.chr    = cell_word[7:0];
        e.rep.fore   = cell_word[11:8];
        e.rep.back   = cell_word[15:12];
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_item(action_t act, logic [7:0] ch, logic [4:0] rrow,
                             logic [6:0] rcol, logic eow);
        console_item_t it;
        it.act  = act;
        it.ch   = ch;
        it.rrow = rrow;
        it.rcol = rcol;
        it.eow  = eow;
        char_stream.push_back(it);
    endtask

    // Write calls of 1..12 beats with tlast on the last one. Mostly printable
    // text with spaces mixed in so that backspace has trailing blanks to skip;
    // newlines are kept sparse since every scroll walks the whole screen.
    task automatic queue_write_calls(int beats);
        console_item_t it;
        int            len;
        int            pick;
        while (beats > 0)
        begin
            len = $urandom_range(12, 1);
            for (int j = 0; j < len && beats > 0; j++)
            begin
                it.act  = ACT_PUT;
                it.ch   = 8'($urandom_range(126, 33));
                it.rrow = 5'($urandom_range(NUM_ROWS - 1, 0));
                it.rcol = 7'($urandom_range(NUM_COLS - 1, 0));
                pick = $urandom_range(99, 0);
                if (pick < 18)
                begin
                    it.act = ACT_READ;
                    it.ch  = 8'($urandom);
                    if (pick < 4)
                    begin
                        it.rrow = 5'($urandom);
                        it.rcol = 7'($urandom);
                    end
                end
                else if (pick < 24)
                    it.ch = NEWLINE_CHAR;
                else if (pick < 33)
                    it.ch = BACKSPACE_CHAR;
                else if (pick < 45)
                    it.ch = SPACE_CHAR;
                else if (pick < 55)
                    it.ch = 8'($urandom);
                it.eow = (j == len - 1 || beats == 1);
                char_stream.push_back(it);
                beats--;
            end
        end
    endtask

    // block is idle once every beat is in, every result is out and s_tready
    // is back up; the task then waits on to cover any tail of a scroll
    task automatic wait_idle();
        do
            @(posedge clk);
        while (char_stream.size() != 0 || s_tvalid || reports_due.size() != 0 || !s_tready);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TEXT_COLOUR)
            fg_reg = val;
        else
            bg_reg = val;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            failed = 1'b1;
            if (err_reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_reports++;
        end
    endtask

    // ---------------------------------------------------------------
    // Clock and timeout
    // ---------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: inputs move on the falling edge only
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a beat on the bus stays put until the monitor saw it taken
            if (!s_tvalid || beat_taken)
            begin
                beat_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
                begin
                    send_gap = $urandom_range(8, 0);
                    s_tvalid <= 1'b0;
                end
                else if (char_stream.size() != 0)
                begin
                    console_item_t it;
                    it = char_stream.pop_front();
                    s_tdata  <= {4'b0, it.rcol, it.rrow, it.ch};
                    s_tuser  <= it.act;
                    s_tlast  <= it.eow;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end

            // receiver back-pressure in random bursts
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
            begin
                recv_gap = $urandom_range(8, 0);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results checked first, then the accepted beat is predicted
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                report_entry_t  want;
                cursor_report_t got;
                got = m_tdata;
                if (reports_due.size() == 0)
                begin
                    failed = 1'b1;
                    if (err_reports < MAX_REPORTS)
                        $display("%0t: result beat with nothing pending, expected none actual %0h",
                                 $time, m_tdata);
                    err_reports++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("cursor_row", want.rep.row, got.row);
                    check_field("cursor_col", want.rep.col, got.col);
                    check_field("cursor_index", want.rep.pos, got.pos);
                    check_field("did_scroll", want.rep.scroll, got.scroll);
                    check_field("cell_char", want.rep.chr, got.chr);
                    check_field("cell_fore", want.rep.fore, got.fore);
                    check_field("cell_back", want.rep.back, got.back);
                    check_field("write_done", want.done, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                console_item_t it;
                it.act  = action_t'(s_tuser);
                it.ch   = s_tdata[7:0];
                it.rrow = s_tdata[12:8];
                it.rcol = s_tdata[19:13];
                it.eow  = s_tlast;
                reports_due.push_back(apply_to_screen(it));
                beat_taken = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed beats, then random phases with the colour
    // registers changed between them (idle only)
    // ---------------------------------------------------------------
    initial
    begin
        int odds_by_phase [PHASES];
        odds_by_phase = '{8, 3, 24, 6, 0};   // last phase runs with no idling

        fg_reg = RESET_TEXT_COLOUR;
        bg_reg = RESET_BACK_COLOUR;
        for (int k = 0; k < NUM_CELLS; k++)
            screen_model[k] = paint(SPACE_CHAR);
        cur_r = 0;
        cur_c = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_odds = odds_by_phase[0];
        // backspace at home does nothing
        push_item(ACT_PUT,  BACKSPACE_CHAR, 5'd0,  7'd0,   1'b0);
        // reads: home, far corner, and out of range on each axis and both
        push_item(ACT_READ, 8'h00,          5'd0,  7'd0,   1'b0);
        push_item(ACT_READ, 8'hFF,          5'd24, 7'd79,  1'b1);
        push_item(ACT_READ, 8'h41,          5'd25, 7'd0,   1'b0);
        push_item(ACT_READ, 8'h00,          5'd0,  7'd80,  1'b0);
        push_item(ACT_READ, 8'hFF,          5'd31, 7'd127, 1'b1);
        // character extremes, a space and a letter
        push_item(ACT_PUT,  8'h00,          5'd31, 7'd127, 1'b0);
        push_item(ACT_PUT,  8'hFF,          5'd0,  7'd0,   1'b0);
        push_item(ACT_PUT,  SPACE_CHAR,     5'd0,  7'd0,   1'b0);
        push_item(ACT_PUT,  8'h41,          5'd0,  7'd0,   1'b1);
        // backspace onto a letter, then over a space onto 0xFF
        push_item(ACT_PUT,  BACKSPACE_CHAR, 5'd0,  7'd0,   1'b0);
        push_item(ACT_PUT,  BACKSPACE_CHAR, 5'd0,  7'd0,   1'b1);
        // newline, then backspace wraps up and skips the blank row tail
        push_item(ACT_PUT,  NEWLINE_CHAR,   5'd0,  7'd0,   1'b0);
        push_item(ACT_PUT,  BACKSPACE_CHAR, 5'd0,  7'd0,   1'b1);
        push_item(ACT_READ, 8'h00,          5'd0,  7'd0,   1'b0);
        push_item(ACT_READ, 8'h00,          5'd0,  7'd1,   1'b1);
        queue_write_calls(BEATS_PER_PHASE - char_stream.size());
        wait_idle();

        for (int ph = 1; ph < PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(REG_TEXT_COLOUR, 4'h0);
                    write_reg(REG_BACK_COLOUR, 4'hF);
                end
                2:
                begin
                    write_reg(REG_TEXT_COLOUR, 4'($urandom));
                    write_reg(REG_BACK_COLOUR, 4'($urandom));
                end
                3:
                begin
                    write_reg(REG_TEXT_COLOUR, 4'hF);
                    write_reg(REG_BACK_COLOUR, 4'hF);
                end
                default:
                begin
                    write_reg(REG_TEXT_COLOUR, 4'h0);
                    write_reg(REG_BACK_COLOUR, 4'h0);
                end
            endcase
            idle_odds = odds_by_phase[ph];
            queue_write_calls(BEATS_PER_PHASE);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (!failed && reports_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
